[rtl/bpp_pkg.sv]
`default_nettype none
package bpp_pkg;
    localparam int NUM_BINS  = 64;
    localparam int BIN_W     = $clog2(NUM_BINS);
    localparam int SUM_W     = 28;
    localparam int CNT_W     = 21;
    localparam int MEAN_W    = 16;
    localparam int COORD_W   = 13;
    localparam int OFF_W     = 10;
    localparam int PIX_W     = 8;
    localparam int BIDX_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_W     = SUM_W + 8;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_ROW = 2'd0,
        REG_ORIGIN_COL = 2'd1,
        REG_IMAGE_ROWS = 2'd2,
        REG_IMAGE_COLS = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_READ,
        ST_LOAD,
        ST_DIVIDE,
        ST_EMIT,
        ST_INIT
    } ctrl_state_t;

    typedef struct packed {
        logic accept_pixel;
        logic rd_start;
        logic div_load;
        logic div_step;
        logic out_load;
        logic bin_advance;
        logic bin_clear;
    } dp_cmd_t;

    typedef struct packed {
        logic pending;
        logic last_pending;
        logic div_done;
        logic bin_is_last;
    } dp_status_t;
endpackage
`default_nettype wire

[rtl/bpp_if.sv]
`default_nettype none
interface bpp_pix_if (input wire logic clk);
    logic                       valid;
    logic                       ready;
    logic [bpp_pkg::OFF_W-1:0]  row_offset;
    logic [bpp_pkg::OFF_W-1:0]  col_offset;
    logic [bpp_pkg::PIX_W-1:0]  pixel_value;
    logic signed [bpp_pkg::BIDX_W-1:0] bin_index;
    logic                       last_pixel;
    modport source (output valid, row_offset, col_offset, pixel_value, bin_index, last_pixel,
                    input ready);
    modport sink (input valid, row_offset, col_offset, pixel_value, bin_index, last_pixel,
                  output ready);
endinterface

interface bpp_res_if (input wire logic clk);
    logic                       valid;
    logic                       ready;
    logic [bpp_pkg::BIN_W-1:0]  bin_number;
    logic [bpp_pkg::MEAN_W-1:0] bin_mean;
    logic                       last_bin;
    modport source (output valid, bin_number, bin_mean, last_bin, input ready);
    modport sink (input valid, bin_number, bin_mean, last_bin, output ready);
endinterface

interface bpp_cfg_if (input wire logic clk);
    logic                          valid;
    logic                          ready;
    logic [bpp_pkg::CFG_IDX_W-1:0] index;
    logic [bpp_pkg::COORD_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/bpp_ctrl.sv]
`default_nettype none
module bpp_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bpp_pkg::dp_status_t status,
    input  wire logic                out_ready,
    output bpp_pkg::dp_cmd_t         cmd,
    output logic                     pix_ready,
    output logic                     out_valid
);
    import bpp_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        pix_ready  = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                // zero one bin per cycle after reset
                cmd.bin_clear = 1'b1;
                if (status.bin_is_last)
                    state_next = ST_ACCUM;
                else
                    cmd.bin_advance = 1'b1;
            end
            ST_ACCUM:
            begin
                // the pending pixel write finishes before emission starts
                if (status.last_pending)
                    state_next = ST_READ;
                else
                    pix_ready = 1'b1;
                cmd.accept_pixel = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd_start = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                    cmd.div_step = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.bin_clear = 1'b1;
                    if (status.bin_is_last)
                        state_next = ST_ACCUM;
                    else
                    begin
                        cmd.bin_advance = 1'b1;
                        state_next      = ST_READ;
                    end
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_ready_only_accum: assert property (@(posedge clk) disable iff (!rst_n)
        pix_ready |-> state_reg == ST_ACCUM)
        else $error("pixel ready outside accumulate");
    a_emit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && $past(state_reg) != ST_EMIT) |-> $past(status.div_done))
        else $error("emit without finished divide");
    a_no_valid_accum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !pix_ready)
        else $error("result and pixel at once");
`endif
endmodule
`default_nettype wire

[rtl/bpp_datapath.sv]
`default_nettype none
module bpp_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bpp_pkg::dp_cmd_t              cmd,
    output bpp_pkg::dp_status_t                status,
    input  wire logic                          pix_fire,
    input  wire logic [bpp_pkg::OFF_W-1:0]     row_offset,
    input  wire logic [bpp_pkg::OFF_W-1:0]     col_offset,
    input  wire logic [bpp_pkg::PIX_W-1:0]     pixel_value,
    input  wire logic [bpp_pkg::BIDX_W-1:0]    bin_index,
    input  wire logic                          last_pixel,
    input  wire logic                          cfg_fire,
    input  wire logic [bpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bpp_pkg::COORD_W-1:0]   cfg_data,
    output logic [bpp_pkg::BIN_W-1:0]          bin_number,
    output logic [bpp_pkg::MEAN_W-1:0]         bin_mean,
    output logic                               last_bin
);
    import bpp_pkg::*;

    logic [COORD_W-1:0] org_row_reg, org_col_reg, img_rows_reg, img_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_row_reg  <= '0;
            org_col_reg  <= '0;
            img_rows_reg <= COORD_W'(4096);
            img_cols_reg <= COORD_W'(4096);
        end
        else if (cfg_fire)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_ROW: org_row_reg  <= cfg_data;
                REG_ORIGIN_COL: org_col_reg  <= cfg_data;
                REG_IMAGE_ROWS: img_rows_reg <= cfg_data;
                REG_IMAGE_COLS: img_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: position test and bin check, registered
    logic signed [COORD_W+1:0] row_pos, col_pos;
    logic in_image, bin_ok;
    logic [BIN_W-1:0] in_bin;
    assign row_pos = (COORD_W+2)'(signed'(org_row_reg)) + signed'((COORD_W+2)'(row_offset));
    assign col_pos = (COORD_W+2)'(signed'(org_col_reg)) + signed'((COORD_W+2)'(col_offset));
    assign in_image = !row_pos[COORD_W+1] && !col_pos[COORD_W+1]
                    && (row_pos < signed'((COORD_W+2)'(img_rows_reg)))
                    && (col_pos < signed'((COORD_W+2)'(img_cols_reg)));
    assign bin_ok  = !bin_index[BIDX_W-1] && (BIDX_W'(NUM_BINS) > bin_index);
    assign in_bin  = bin_index[BIN_W-1:0];

    logic             p_valid_reg, p_last_reg, p_inside_reg;
    logic [BIN_W-1:0] p_bin_reg;
    logic [PIX_W-1:0] p_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
        end
        else if (cmd.accept_pixel)
        begin
            p_valid_reg <= pix_fire && bin_ok;
            p_last_reg  <= pix_fire && last_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            p_inside_reg <= in_image;
            p_bin_reg    <= in_bin;
            p_pix_reg    <= pixel_value;
        end
    end

    // bin stores: registered read at the incoming bin, forwarded from the write
    // one stage ahead when both hit the same bin
    logic [SUM_W-1:0] sums_mem   [NUM_BINS];
    logic [CNT_W-1:0] counts_mem [NUM_BINS];
    logic [BIN_W-1:0] emit_bin_reg;
    logic [SUM_W-1:0] cur_sum_reg, new_sum, rd_sum_reg;
    logic [CNT_W-1:0] cur_cnt_reg, new_cnt, rd_cnt_reg;
    logic [SUM_W:0]   sum_add;
    logic             commit;

    assign commit  = p_valid_reg && cmd.accept_pixel;
    assign sum_add = {1'b0, cur_sum_reg} + (SUM_W+1)'(p_pix_reg);
    assign new_cnt = (cur_cnt_reg != CNT_MAX) ? cur_cnt_reg + CNT_W'(1) : cur_cnt_reg;
    assign new_sum = !p_inside_reg ? cur_sum_reg
                   : (sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.bin_clear)
        begin
            sums_mem[emit_bin_reg]   <= '0;
            counts_mem[emit_bin_reg] <= '0;
        end
        else if (commit)
        begin
            sums_mem[p_bin_reg]   <= new_sum;
            counts_mem[p_bin_reg] <= new_cnt;
        end
        if (pix_fire)
        begin
            if (commit && p_bin_reg == in_bin)
            begin
                cur_sum_reg <= new_sum;
                cur_cnt_reg <= new_cnt;
            end
            else
            begin
                cur_sum_reg <= sums_mem[in_bin];
                cur_cnt_reg <= counts_mem[in_bin];
            end
        end
        if (cmd.rd_start)
        begin
            rd_sum_reg <= sums_mem[emit_bin_reg];
            rd_cnt_reg <= counts_mem[emit_bin_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            emit_bin_reg <= '0;
        else if (cmd.bin_advance)
            emit_bin_reg <= emit_bin_reg + BIN_W'(1);
        else if (cmd.bin_clear)
            emit_bin_reg <= '0;
    end

    // restoring divider, one quotient bit a cycle
    logic [NUM_W-1:0]     quo_reg;
    logic [CNT_W:0]       rem_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [CNT_W:0]       rem_shift, rem_sub;

    assign rem_shift = {rem_reg[CNT_W-1:0], quo_reg[NUM_W-1]};
    assign rem_sub   = rem_shift - {1'b0, rd_cnt_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg  <= {rd_sum_reg, 8'd0};
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_sub[CNT_W])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
            step_reg <= step_reg + DIV_CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            bin_number <= emit_bin_reg;
            last_bin   <= (emit_bin_reg == BIN_W'(NUM_BINS - 1));
            if (rd_cnt_reg == '0)
                bin_mean <= '0;
            else if (quo_reg[NUM_W-1:MEAN_W] != '0)
                bin_mean <= {MEAN_W{1'b1}};
            else
                bin_mean <= quo_reg[MEAN_W-1:0];
        end
    end

    assign status.pending      = p_valid_reg;
    assign status.last_pending = p_last_reg;
    assign status.div_done     = (step_reg == DIV_CNT_W'(DIV_STEPS));
    assign status.bin_is_last  = (emit_bin_reg == BIN_W'(NUM_BINS - 1));

`ifndef NO_ASSERTIONS
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> step_reg < DIV_CNT_W'(DIV_STEPS))
        else $error("divider ran past its steps");
    a_clear_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.bin_clear && !cmd.bin_advance) |=> emit_bin_reg == '0)
        else $error("emit bin not rewound");
    a_no_pixel_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bin_clear |-> !cmd.accept_pixel)
        else $error("pixel update during emission");
`endif
endmodule
`default_nettype wire

[rtl/binned_projection_profile.sv]
`default_nettype none
// binned projection profile: bins box pixels into per-bin gray sums and counts,
// then reports one mean per bin after the pixel marked last
// pix channel: one box pixel per request, row/col offset, gray value, bin index
// cfg channel: register index and data, writes box origin and image size
// res channel: one request per bin, bin_number 0 upward, mean in 8.8, last_bin
// on the final bin
// pixels are taken one per cycle while accumulating; the store update is one
// register stage behind the accepted request, with forwarding between neighbors
// after the last pixel the block stops taking pixels, commits the pending write
// and then emits 64 results; each bin runs read, load, 36 divide steps, an
// output load and an emit step; pixels are taken again once the final result
// has been taken
// a stalled receiver holds the result and the sequencer waits; the bin is
// cleared when its result is taken
// reset sets origin 0 and image size 4096 by 4096, then a pass over all 64 bins
// zeroes the bin stores while pix ready stays low
module binned_projection_profile (
    input  wire logic clk,
    input  wire logic rst_n,
    bpp_pix_if.sink   pix,
    bpp_cfg_if.sink   cfg,
    bpp_res_if.source res
);
    import bpp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       pix_ready;

    // config is always accepted
    assign cfg.ready = 1'b1;
    assign pix.ready = pix_ready;

    bpp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .out_ready (res.ready),
        .cmd       (cmd),
        .pix_ready (pix_ready),
        .out_valid (res.valid)
    );

    bpp_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .pix_fire    (pix.valid && pix_ready),
        .row_offset  (pix.row_offset),
        .col_offset  (pix.col_offset),
        .pixel_value (pix.pixel_value),
        .bin_index   (pix.bin_index),
        .last_pixel  (pix.last_pixel),
        .cfg_fire    (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .bin_number  (res.bin_number),
        .bin_mean    (res.bin_mean),
        .last_bin    (res.last_bin)
    );

`ifndef NO_ASSERTIONS
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> res.valid && $stable(res.bin_number))
        else $error("result dropped while stalled");
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && res.last_bin) |=> !res.valid)
        else $error("results after final bin");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !pix.ready)
        else $error("pixel taken during emission");
`endif
endmodule
`default_nettype wire
